/* rtl/core/pid_aw_pkg.sv */
// Shared types and constants for the PID regulator with back-calculation anti-windup.
// No dependencies; imported by pid_antiwindup_regulator.
package pid_aw_pkg;

    // Integral clamp magnitude
    localparam int unsigned INTEGRAL_LIMIT = 65535;

    // Field widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned ERR_W    = SAMPLE_W + 1;
    localparam int unsigned DIFF_W   = ERR_W + 1;
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned GAIN_W   = 15;
    localparam int unsigned SHIFT_W  = 5;
    localparam int unsigned DRIVE_W  = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ERR_W-1:0]    err_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [GAIN_W-1:0]          gain_t;
    typedef logic [SHIFT_W-1:0]         shift_t;
    typedef logic [DRIVE_W-1:0]         drive_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

    // Configuration register indexes
    localparam cfg_idx_t REG_PROP_GAIN   = 3'd0;
    localparam cfg_idx_t REG_PROP_SHIFT  = 3'd1;
    localparam cfg_idx_t REG_INTEG_GAIN  = 3'd2;
    localparam cfg_idx_t REG_INTEG_SHIFT = 3'd3;
    localparam cfg_idx_t REG_DERIV_GAIN  = 3'd4;
    localparam cfg_idx_t REG_DERIV_SHIFT = 3'd5;
    localparam cfg_idx_t REG_OUT_LOW     = 3'd6;
    localparam cfg_idx_t REG_OUT_HIGH    = 3'd7;

    // Reset value of the upper drive limit
    localparam drive_t OUT_HIGH_RESET = 16'hFFFF;

endpackage

/* rtl/core/pid_antiwindup_regulator.sv */
// PID regulator with integral clamping and back-calculation anti-windup.
// Depends on pid_aw_pkg (types, widths, register indexes).
//
//  channel   ports                                  direction
//  --------  -------------------------------------  ---------
//  input     s_valid s_ready s_target s_measured    in
//  result    m_valid m_ready m_drive                out
//  config    cfg_we cfg_index cfg_wdata             in
//
// One item per cycle while the result is not stalled; an accepted input goes into
// the input register, then its drive into the result register that is offered.
// An input register feeds one combinational pass (three products cut to 32 bits,
// clamp, shifts, sum, output clamp) that writes the result register and the
// integral and previous-error state at the same edge.
// A stalled result holds the pass; the input register still takes one item.
// Synchronous active-low reset clears valids, state and config; out_high is all ones.
module pid_antiwindup_regulator (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pid_aw_pkg::sample_t  s_target,
    input  pid_aw_pkg::sample_t  s_measured,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pid_aw_pkg::drive_t   m_drive,
    input  logic                 cfg_we,
    input  pid_aw_pkg::cfg_idx_t cfg_index,
    input  pid_aw_pkg::cfg_data_t cfg_wdata
);
    import pid_aw_pkg::*;

    // Configuration registers
    gain_t  prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    shift_t prop_shift_reg, integ_shift_reg, deriv_shift_reg;
    drive_t out_low_reg, out_high_reg;

    // Pipeline registers
    logic    in_valid_reg;
    sample_t target_reg, measured_reg;
    logic    out_valid_reg;
    drive_t  drive_reg, drive_next;

    // Loop state
    acc_t integral_reg, integral_next;
    err_t prev_err_reg, prev_err_next;

    logic advance;
    logic fire;

    // Handshake: the pass moves when the result slot is free or being taken
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_drive = drive_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            prop_shift_reg  <= '0;
            integ_gain_reg  <= '0;
            integ_shift_reg <= '0;
            deriv_gain_reg  <= '0;
            deriv_shift_reg <= '0;
            out_low_reg     <= '0;
            out_high_reg    <= OUT_HIGH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_PROP_SHIFT:  prop_shift_reg  <= cfg_wdata[SHIFT_W-1:0];
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_SHIFT: integ_shift_reg <= cfg_wdata[SHIFT_W-1:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_DERIV_SHIFT: deriv_shift_reg <= cfg_wdata[SHIFT_W-1:0];
                REG_OUT_LOW:     out_low_reg     <= cfg_wdata[DRIVE_W-1:0];
                REG_OUT_HIGH:    out_high_reg    <= cfg_wdata[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            target_reg   <= s_target;
            measured_reg <= s_measured;
        end
    end

    // Controller pass
    logic signed [ERR_W-1:0]    err;
    logic signed [DIFF_W-1:0]   derr;
    logic signed [ACC_W:0]      p_full;
    logic signed [ACC_W:0]      i_full;
    logic signed [DIFF_W+GAIN_W:0] d_full;
    acc_t p_term, i_prod, d_raw, d_term;
    acc_t aux, i_clamped, i_mid;
    acc_t p_sh, i_sh, d_sh, sum;
    acc_t hi_ext, lo_ext;

    always_comb begin
        err    = ERR_W'(target_reg) - ERR_W'(measured_reg);
        derr   = DIFF_W'(err) - DIFF_W'(prev_err_reg);
        p_full = (ACC_W+1)'($signed({1'b0, prop_gain_reg})) * (ACC_W+1)'(err);
        i_full = (ACC_W+1)'($signed({1'b0, integ_gain_reg})) * (ACC_W+1)'(err);
        d_full = (DIFF_W+GAIN_W+1)'($signed({1'b0, deriv_gain_reg}))
               * (DIFF_W+GAIN_W+1)'(derr);
        p_term = p_full[ACC_W-1:0];
        i_prod = i_full[ACC_W-1:0];
        d_raw  = d_full[ACC_W-1:0];

        // Accumulate and clamp the integral
        aux = integral_reg + i_prod;
        if (aux > $signed(ACC_W'(INTEGRAL_LIMIT))) begin
            i_clamped = ACC_W'(INTEGRAL_LIMIT);
        end else if (aux < -$signed(ACC_W'(INTEGRAL_LIMIT))) begin
            i_clamped = -$signed(ACC_W'(INTEGRAL_LIMIT));
        end else begin
            i_clamped = aux;
        end

        // Zero integral gain drops I and D and freezes the previous error
        if (integ_gain_reg == '0) begin
            i_mid         = '0;
            d_term        = '0;
            prev_err_next = prev_err_reg;
        end else begin
            i_mid         = i_clamped;
            d_term        = d_raw;
            prev_err_next = err;
        end

        p_sh = p_term >>> prop_shift_reg;
        i_sh = i_mid >>> integ_shift_reg;
        d_sh = d_term >>> deriv_shift_reg;
        sum  = p_sh + i_sh + d_sh;

        // Clamp the drive and feed the overshoot back into the integral
        hi_ext = $signed({{(ACC_W-DRIVE_W){1'b0}}, out_high_reg});
        lo_ext = $signed({{(ACC_W-DRIVE_W){1'b0}}, out_low_reg});
        if (sum >= hi_ext) begin
            drive_next    = out_high_reg;
            integral_next = i_mid + (hi_ext - sum);
        end else if (sum < lo_ext) begin
            drive_next    = out_low_reg;
            integral_next = i_mid + (lo_ext - sum);
        end else begin
            drive_next    = sum[DRIVE_W-1:0];
            integral_next = i_mid;
        end
    end

    // Advance state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                integral_reg <= integral_next;
                prev_err_reg <= prev_err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            drive_reg <= drive_next;
        end
    end

    // Checks
    a_drive_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_low_reg <= out_high_reg) |->
            (drive_reg >= out_low_reg && drive_reg <= out_high_reg))
        else $error("drive outside configured limits");

    a_prev_err_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && integ_gain_reg == '0) |=> $stable(prev_err_reg))
        else $error("previous error changed with zero integral gain");

    a_state_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> ($stable(integral_reg) && $stable(prev_err_reg)))
        else $error("loop state changed without a pass");

endmodule

/* test/pid_antiwindup_regulator_tb.sv */
// Self-checking testbench for the PID regulator with back-calculation anti-windup.
// Drives directed and random set points with random idling on both channels.
// Depends on pid_aw_pkg and pid_antiwindup_regulator.
module pid_antiwindup_regulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pid_aw_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_BLOCKS    = 11;
    localparam int BLOCK_ITEMS    = 100;
    localparam int STALL_CYCLES   = 80;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct packed {
        gain_t  kp;
        shift_t kp_sh;
        gain_t  ki;
        shift_t ki_sh;
        gain_t  kd;
        shift_t kd_sh;
        drive_t lo;
        drive_t hi;
    } pid_cfg_t;

    // One directed set point; known rows carry a hand-derived drive value
    typedef struct packed {
        int     set;
        int     tgt;
        int     meas;
        logic   known;
        drive_t drv;
    } step_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sample_t   s_target = '0;
    sample_t   s_measured = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    drive_t    m_drive;
    logic      cfg_we = 1'b0;
    cfg_idx_t  cfg_index = '0;
    cfg_data_t cfg_wdata = '0;

    // Shadow configuration and controller state
    gain_t       kp, ki, kd;
    shift_t      kp_sh, ki_sh, kd_sh;
    drive_t      lo_lim, hi_lim;
    logic [31:0] integ;
    int          last_err;

    drive_t drive_q [$];
    int     mismatches = 0;
    int     src_idle = 0;
    int     snk_idle = 0;
    int     stall_asks = 0;
    int     stall_seen = 0;
    int     stall_left = 0;
    int     quiet_cycles = 0;

    localparam pid_cfg_t DIR_CFG [5] = '{
        '{15'd0,     5'd0,  15'd0,     5'd0,  15'd0,     5'd0,  16'd0,     16'hFFFF},
        '{15'd1,     5'd0,  15'd0,     5'd0,  15'd0,     5'd0,  16'd0,     16'hFFFF},
        '{15'd32767, 5'd31, 15'd32767, 5'd31, 15'd32767, 5'd31, 16'd0,     16'hFFFF},
        '{15'd1,     5'd0,  15'd0,     5'd0,  15'd0,     5'd0,  16'd40000, 16'd1000},
        '{15'd4,     5'd2,  15'd100,   5'd4,  15'd50,    5'd3,  16'd1000,  16'd60000}
    };

    // Set 0 runs on reset values; set 1 is a plain clamped error; set 3 has
    // inverted limits with the integral off, so its rows read off directly.
    localparam step_row_t STEPS [23] = '{
        '{0,      0,      0, 1'b1, 16'd0},
        '{0,  32767, -32768, 1'b1, 16'd0},
        '{0, -32768,  32767, 1'b1, 16'd0},
        '{1,  32767, -32768, 1'b1, 16'd65535},
        '{1, -32768,  32767, 1'b1, 16'd0},
        '{1,    100,      0, 1'b1, 16'd100},
        '{1,      0,      0, 1'b1, 16'd0},
        '{1,     -1,     -1, 1'b1, 16'd0},
        '{2,  32767, -32768, 1'b0, 16'd0},
        '{2, -32768,  32767, 1'b0, 16'd0},
        '{2,      0,      0, 1'b0, 16'd0},
        '{2,  32767,  32767, 1'b0, 16'd0},
        '{2,     -1,      0, 1'b0, 16'd0},
        '{3,   5000,      0, 1'b1, 16'd1000},
        '{3,      0,      0, 1'b1, 16'd40000},
        '{3, -32768,  32767, 1'b1, 16'd40000},
        '{4,   1000,      0, 1'b0, 16'd0},
        '{4,   1000,      0, 1'b0, 16'd0},
        '{4,   1000,      0, 1'b0, 16'd0},
        '{4, -32768,  32767, 1'b0, 16'd0},
        '{4, -32768,  32767, 1'b0, 16'd0},
        '{4,      0,      0, 1'b0, 16'd0},
        '{4,  32767, -32768, 1'b0, 16'd0}
    };

    pid_antiwindup_regulator i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_target   (s_target),
        .s_measured (s_measured),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] shift_arith(logic [31:0] v, shift_t s);
        return $unsigned($signed(v) >>> s);
    endfunction

    // Advance the controller by one set point and return the drive it yields
    function automatic drive_t next_drive(sample_t tgt, sample_t meas);
        int          err;
        int          aux;
        int          res;
        int          lim;
        int          lo;
        int          hi;
        logic [31:0] uerr;
        logic [31:0] p_term;
        logic [31:0] d_term;
        logic [31:0] sum;
        logic [31:0] trim;
        err    = int'(tgt) - int'(meas);
        uerr   = err;
        lim    = int'(INTEGRAL_LIMIT);
        lo     = int'(lo_lim);
        hi     = int'(hi_lim);
        p_term = {17'd0, kp} * uerr;
        d_term = '0;
        trim   = '0;
        if (ki == '0) begin
            integ = '0;
        end else begin
            aux = $signed(integ + {17'd0, ki} * uerr);
            if (aux > lim)
                aux = lim;
            else if (aux < -lim)
                aux = -lim;
            integ    = aux;
            d_term   = {17'd0, kd} * (uerr - last_err);
            last_err = err;
        end
        sum = shift_arith(p_term, kp_sh) + shift_arith(integ, ki_sh)
            + shift_arith(d_term, kd_sh);
        res = $signed(sum);
        // Upper clamp wins, also when the limits are inverted
        if (res >= hi) begin
            trim = hi - sum;
            res  = hi;
        end else if (res < lo) begin
            trim = lo - sum;
            res  = lo;
        end
        integ = integ + trim;
        return res[15:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Write one register; load_cfg puts random junk above each gain and shift field
    task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic load_cfg(pid_cfg_t c);
        write_reg(REG_PROP_GAIN,   {1'($urandom), c.kp});
        write_reg(REG_PROP_SHIFT,  {11'($urandom), c.kp_sh});
        write_reg(REG_INTEG_GAIN,  {1'($urandom), c.ki});
        write_reg(REG_INTEG_SHIFT, {11'($urandom), c.ki_sh});
        write_reg(REG_DERIV_GAIN,  {1'($urandom), c.kd});
        write_reg(REG_DERIV_SHIFT, {11'($urandom), c.kd_sh});
        write_reg(REG_OUT_LOW,     c.lo);
        write_reg(REG_OUT_HIGH,    c.hi);
        cfg_we <= 1'b0;
        kp = c.kp; kp_sh = c.kp_sh;
        ki = c.ki; ki_sh = c.ki_sh;
        kd = c.kd; kd_sh = c.kd_sh;
        lo_lim = c.lo; hi_lim = c.hi;
    endtask

    // Hold the sender until every expected drive has arrived
    task automatic drain();
        while (drive_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Offer one set point; entered and left just after a falling edge
    task automatic send_point(sample_t tgt, sample_t meas, logic known, drive_t drv);
        drive_t pred;
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_target   <= tgt;
        s_measured <= meas;
        do
            @(posedge aclk);
        while (!s_ready);
        pred = next_drive(tgt, meas);
        drive_q.push_back(known ? drv : pred);
        @(negedge aclk);
    endtask

    function automatic gain_t pick_gain();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return gain_t'($urandom_range(1, 63));
            2: return gain_t'($urandom);
            default: return '1;
        endcase
    endfunction

    function automatic shift_t pick_shift();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return shift_t'($urandom);
        endcase
    endfunction

    function automatic pid_cfg_t random_cfg();
        pid_cfg_t c;
        c.kp    = pick_gain();
        c.kp_sh = pick_shift();
        c.ki    = ($urandom_range(0, 4) == 0) ? gain_t'(0) : pick_gain();
        c.ki_sh = pick_shift();
        c.kd    = pick_gain();
        c.kd_sh = pick_shift();
        case ($urandom_range(0, 5))
            0: begin c.lo = '0; c.hi = '1; end
            1: begin c.lo = drive_t'($urandom); c.hi = drive_t'($urandom); end
            default: begin
                c.lo = drive_t'($urandom_range(0, 20000));
                c.hi = drive_t'($urandom_range(30000, 65535));
            end
        endcase
        return c;
    endfunction

    function automatic sample_t pick_extreme();
        case ($urandom_range(0, 3))
            0: return sample_t'(-32768);
            1: return sample_t'(32767);
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // Receiver: random back-pressure plus one long hold-off on request
    always @(negedge aclk) begin
        if (stall_seen != stall_asks) begin
            stall_seen = stall_asks;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    // Compare each result transfer with the oldest expected drive
    always @(posedge aclk) begin
        drive_t want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_q.size() == 0) begin
                report_mismatch($sformatf("unexpected drive %0d", m_drive));
            end else begin
                want = drive_q.pop_front();
                if (m_drive !== want)
                    report_mismatch($sformatf("drive got %0d want %0d", m_drive, want));
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int      cur_set;
        int      t;
        sample_t tgt;
        sample_t meas;
        kp = '0; kp_sh = '0; ki = '0; ki_sh = '0; kd = '0; kd_sh = '0;
        lo_lim = '0; hi_lim = OUT_HIGH_RESET;
        integ = '0; last_err = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows, switching settings only while the block is idle
        cur_set = 0;
        foreach (STEPS[i]) begin
            if (STEPS[i].set != cur_set) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                drain();
                cur_set = STEPS[i].set;
                load_cfg(DIR_CFG[cur_set]);
            end
            send_point(sample_t'(STEPS[i].tgt), sample_t'(STEPS[i].meas),
                       STEPS[i].known, STEPS[i].drv);
        end

        // Random blocks, each under fresh settings and an idling pattern
        for (int b = 0; b < RAND_BLOCKS; b++) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            drain();
            if (b == 0)
                load_cfg('{15'd32767, 5'd0, 15'd32767, 5'd0, 15'd32767, 5'd0,
                           16'd65535, 16'd0});
            else
                load_cfg(random_cfg());
            if (b < 4) begin
                src_idle = 25; snk_idle = 72;
            end else if (b < 8) begin
                src_idle = 72; snk_idle = 25;
            end else begin
                src_idle = 0; snk_idle = 0;
            end
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                if (b == 9 && n == 30)
                    stall_asks++;
                case ($urandom_range(0, 7))
                    0: begin
                        tgt  = pick_extreme();
                        meas = pick_extreme();
                    end
                    1, 2: begin
                        tgt  = sample_t'($urandom);
                        meas = sample_t'($urandom);
                    end
                    default: begin
                        // Track a measured value closely, as in closed loop
                        meas = sample_t'($urandom);
                        t = int'(meas) + int'($urandom_range(0, 511)) - 256;
                        if (t > 32767)
                            t = 32767;
                        else if (t < -32768)
                            t = -32768;
                        tgt = sample_t'(t);
                    end
                endcase
                send_point(tgt, meas, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (drive_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
